[rtl/mlfq_pkg.sv]
// Package for the multilevel feedback queue scheduler.
// Holds transaction payload types, command and status codes, and sequencer states.
// No dependencies.
`default_nettype none

package mlfq_pkg;

    localparam int PID_W       = 16;
    localparam int BURST_W     = 16;
    localparam int TIME_W      = 32;
    localparam int LEVEL_OUT_W = 3;
    localparam int QUANTUM_W   = 8;
    localparam int BOOST_W     = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 8'd1;
    localparam logic [BOOST_W-1:0]   BOOST_RESET   = 16'd8;

    typedef enum logic {
        CMD_ADD  = 1'b0,
        CMD_TICK = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_RAN       = 3'd1,
        ST_COMPLETED = 3'd2,
        ST_ADDED     = 3'd3,
        ST_FULL      = 3'd4,
        ST_ALL_DONE  = 3'd5
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUANTUM        = 1'b0,
        CFG_BOOST_INTERVAL = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_SCAN,
        S_EVAL,
        S_PUSH,
        S_BCHK,
        S_BSCAN,
        S_BMOVE,
        S_DONE
    } t_state;

    typedef struct packed {
        t_cmd                 cmd;
        logic [PID_W-1:0]     new_pid;
        logic [BURST_W-1:0]   new_burst;
        logic [TIME_W-1:0]    new_start;
    } t_in_item;

    typedef struct packed {
        t_status                status;
        logic [PID_W-1:0]       run_pid;
        logic [LEVEL_OUT_W-1:0] run_level;
        logic [TIME_W-1:0]      run_time;
    } t_out_item;

    typedef struct packed {
        logic [PID_W-1:0]   pid;
        logic [BURST_W-1:0] burst;
        logic [TIME_W-1:0]  start;
    } t_task;

    typedef struct packed {
        logic pop;
        logic push;
        logic push0;
        logic add;
        logic retire;
    } t_qcmd;

endpackage

`default_nettype wire

[rtl/mlfq_in_if.sv]
// Input channel of the scheduler: valid, ready and one command transaction.
// Depends on mlfq_pkg.
`default_nettype none

interface mlfq_in_if;
    logic               valid;
    logic               ready;
    mlfq_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/mlfq_out_if.sv]
// Output channel of the scheduler: valid, ready and one result transaction.
// Depends on mlfq_pkg.
`default_nettype none

interface mlfq_out_if;
    logic                valid;
    logic                ready;
    mlfq_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/mlfq_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module mlfq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 80,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/mlfq_qptr.sv]
// Per-level queue pointers: head, tail and count of each level, plus the held total.
// Depends on mlfq_pkg for the update command struct.
`default_nettype none

module mlfq_qptr #(
    parameter int NUM_LEVELS = 5,
    parameter int MAX_TASKS  = 16,
    localparam int LW = $clog2(NUM_LEVELS),
    localparam int IW = $clog2(MAX_TASKS),
    localparam int CW = $clog2(MAX_TASKS + 1)
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic [LW-1:0]   i_lvl,
    input  wire mlfq_pkg::t_qcmd i_cmd,
    output logic      [IW-1:0]   o_head,
    output logic      [IW-1:0]   o_tail,
    output logic      [CW-1:0]   o_count,
    output logic      [IW-1:0]   o_tail0,
    output logic      [CW-1:0]   o_total
);

    logic [IW-1:0] r_head  [NUM_LEVELS];
    logic [IW-1:0] r_tail  [NUM_LEVELS];
    logic [CW-1:0] r_count [NUM_LEVELS];
    logic [CW-1:0] r_total;
    logic [IW-1:0] n_head  [NUM_LEVELS];
    logic [IW-1:0] n_tail  [NUM_LEVELS];
    logic [CW-1:0] n_count [NUM_LEVELS];
    logic [CW-1:0] n_total;

    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] x);
        return (x == IW'(MAX_TASKS - 1)) ? '0 : x + 1'b1;
    endfunction

    assign o_head  = r_head[i_lvl];
    assign o_tail  = r_tail[i_lvl];
    assign o_count = r_count[i_lvl];
    assign o_tail0 = r_tail[0];
    assign o_total = r_total;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        n_total = r_total + CW'(i_cmd.add) - CW'(i_cmd.retire);
        if (i_cmd.pop) begin
            n_head[i_lvl] = wrap_inc(r_head[i_lvl]);
        end
        if (i_cmd.push) begin
            n_tail[i_lvl] = wrap_inc(r_tail[i_lvl]);
        end
        n_count[i_lvl] = r_count[i_lvl] + CW'(i_cmd.push) - CW'(i_cmd.pop);
        if (i_cmd.push0) begin
            n_tail[0]  = wrap_inc(r_tail[0]);
            n_count[0] = r_count[0] + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LEVELS; i++) begin
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_count[i] <= '0;
            end
            r_total <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_total <= n_total;
        end
    end

endmodule

`default_nettype wire

[rtl/mlfq_scheduler_top.sv]
// Multilevel feedback queue scheduler top level: sequencer, config registers, output stage.
// Depends on mlfq_pkg, mlfq_in_if, mlfq_out_if, mlfq_ram and mlfq_qptr.
//
// Usage:
//   i_in carries one command transaction (add a task or run one scheduling tick);
//   o_out returns exactly one result transaction for each command, in order.
//   Configuration (quantum, boost interval) is written through i_cfg_we / i_cfg_index /
//   i_cfg_wdata while no command is in flight.
//   Tasks live in one RAM with registered read data; each level is a circular queue
//   in its own region of that RAM. A tick scans the levels from 0 up, skipping empty
//   ones; at a visited level the head task is read from RAM and then evaluated. A task
//   not yet startable rotates to the tail of its level and the scan moves on, or ends
//   idle at the last level; a task that runs completes or is pushed one level down (or
//   stays at the last level), followed by a boost check and the result. A boost scans
//   the levels from 1 up and moves each of their tasks to the tail of level 0.
//   One command is processed at a time; i_in.ready is high in the idle state only,
//   the cycle after the result enters o_out, even while that result still waits there.
//   A stalled receiver holds the finished result in the sequencer until o_out frees up.
//   Reset empties all queues, clears time and boost counter, and loads quantum 1 and
//   boost interval 8. The task RAM needs no clearing.
`default_nettype none

module mlfq_scheduler_top #(
    parameter int NUM_LEVELS = 5,
    parameter int MAX_TASKS  = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [mlfq_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [mlfq_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    mlfq_in_if.sink                             i_in,
    mlfq_out_if.source                          o_out
);

    localparam int LW    = $clog2(NUM_LEVELS);
    localparam int IW    = $clog2(MAX_TASKS);
    localparam int CW    = $clog2(MAX_TASKS + 1);
    localparam int SLOTS = NUM_LEVELS * MAX_TASKS;
    localparam int AW    = $clog2(SLOTS);
    localparam int DW    = $bits(mlfq_pkg::t_task);
    localparam logic [LW-1:0] LAST_LVL = LW'(NUM_LEVELS - 1);

    mlfq_pkg::t_state    r_state, n_state;
    logic [LW-1:0]       r_lvl, n_lvl;
    logic [mlfq_pkg::TIME_W-1:0]    r_time, n_time;
    logic [mlfq_pkg::BOOST_W-1:0]   r_boost, n_boost;
    logic [mlfq_pkg::QUANTUM_W-1:0] r_quantum;
    logic [mlfq_pkg::BOOST_W-1:0]   r_interval;
    mlfq_pkg::t_in_item  r_item, n_item;
    mlfq_pkg::t_out_item r_res, n_res;
    mlfq_pkg::t_task     r_wtask, n_wtask;
    logic                r_ov, n_ov;
    mlfq_pkg::t_out_item r_out, n_out;

    mlfq_pkg::t_qcmd     qcmd;
    logic [IW-1:0]       q_head, q_tail, q_tail0;
    logic [CW-1:0]       q_count, q_total;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr, ram_raddr, tail_addr;
    logic [DW-1:0]       ram_wdata, ram_rdata;
    mlfq_pkg::t_task     rd_task;
    logic [mlfq_pkg::BURST_W-1:0] quantum_ext;

    mlfq_ram #(
        .WIDTH (DW),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    mlfq_qptr #(
        .NUM_LEVELS (NUM_LEVELS),
        .MAX_TASKS  (MAX_TASKS)
    ) u_qptr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_lvl   (r_lvl),
        .i_cmd   (qcmd),
        .o_head  (q_head),
        .o_tail  (q_tail),
        .o_count (q_count),
        .o_tail0 (q_tail0),
        .o_total (q_total)
    );

    assign rd_task     = mlfq_pkg::t_task'(ram_rdata);
    assign ram_raddr   = AW'(r_lvl) * AW'(MAX_TASKS) + AW'(q_head);
    assign tail_addr   = AW'(r_lvl) * AW'(MAX_TASKS) + AW'(q_tail);
    assign quantum_ext = mlfq_pkg::BURST_W'(r_quantum);

    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;

    always_comb begin
        n_state   = r_state;
        n_lvl     = r_lvl;
        n_time    = r_time;
        n_boost   = r_boost;
        n_item    = r_item;
        n_res     = r_res;
        n_wtask   = r_wtask;
        n_ov      = r_ov && !o_out.ready;
        n_out     = r_out;
        qcmd      = '0;
        ram_we    = 1'b0;
        ram_waddr = tail_addr;
        ram_wdata = rd_task;
        i_in.ready = 1'b0;

        case (r_state)
            mlfq_pkg::S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_item = i_in.data;
                    n_lvl  = '0;
                    if (i_in.data.cmd == mlfq_pkg::CMD_ADD) begin
                        n_state = mlfq_pkg::S_ADD;
                    end else if (q_total == '0) begin
                        n_res.status    = mlfq_pkg::ST_ALL_DONE;
                        n_res.run_pid   = '0;
                        n_res.run_level = '0;
                        n_res.run_time  = '0;
                        n_state         = mlfq_pkg::S_DONE;
                    end else begin
                        n_state = mlfq_pkg::S_SCAN;
                    end
                end
            end
            mlfq_pkg::S_ADD: begin
                n_res.run_pid   = r_item.new_pid;
                n_res.run_level = '0;
                n_res.run_time  = r_time;
                if (q_total >= CW'(MAX_TASKS)) begin
                    n_res.status = mlfq_pkg::ST_FULL;
                end else begin
                    ram_we          = 1'b1;
                    ram_wdata       = {r_item.new_pid, r_item.new_burst, r_item.new_start};
                    qcmd.push       = 1'b1;
                    qcmd.add        = 1'b1;
                    n_res.status    = mlfq_pkg::ST_ADDED;
                end
                n_state = mlfq_pkg::S_DONE;
            end
            mlfq_pkg::S_SCAN: begin
                if (q_count == '0) begin
                    if (r_lvl == LAST_LVL) begin
                        n_res.status    = mlfq_pkg::ST_IDLE;
                        n_res.run_pid   = '0;
                        n_res.run_level = '0;
                        n_res.run_time  = r_time;
                        n_time          = r_time + 1'b1;
                        n_state         = mlfq_pkg::S_BCHK;
                    end else begin
                        n_lvl = r_lvl + 1'b1;
                    end
                end else begin
                    n_state = mlfq_pkg::S_EVAL;
                end
            end
            mlfq_pkg::S_EVAL: begin
                qcmd.pop = 1'b1;
                if (rd_task.start > r_time) begin
                    // not yet startable: rotate to the tail of this level
                    ram_we    = 1'b1;
                    qcmd.push = 1'b1;
                    if (r_lvl == LAST_LVL) begin
                        n_res.status    = mlfq_pkg::ST_IDLE;
                        n_res.run_pid   = '0;
                        n_res.run_level = '0;
                        n_res.run_time  = r_time;
                        n_time          = r_time + 1'b1;
                        n_state         = mlfq_pkg::S_BCHK;
                    end else begin
                        n_lvl   = r_lvl + 1'b1;
                        n_state = mlfq_pkg::S_SCAN;
                    end
                end else begin
                    n_res.run_pid   = rd_task.pid;
                    n_res.run_level = mlfq_pkg::LEVEL_OUT_W'(r_lvl);
                    n_res.run_time  = r_time;
                    n_time          = r_time + mlfq_pkg::TIME_W'(r_quantum);
                    n_boost         = r_boost + 1'b1;
                    if (rd_task.burst <= quantum_ext) begin
                        n_res.status = mlfq_pkg::ST_COMPLETED;
                        qcmd.retire  = 1'b1;
                        n_state      = mlfq_pkg::S_BCHK;
                    end else begin
                        n_res.status  = mlfq_pkg::ST_RAN;
                        n_wtask.pid   = rd_task.pid;
                        n_wtask.burst = rd_task.burst - quantum_ext;
                        n_wtask.start = rd_task.start;
                        if (r_lvl != LAST_LVL) begin
                            n_lvl = r_lvl + 1'b1;
                        end
                        n_state = mlfq_pkg::S_PUSH;
                    end
                end
            end
            mlfq_pkg::S_PUSH: begin
                ram_we    = 1'b1;
                ram_wdata = r_wtask;
                qcmd.push = 1'b1;
                n_state   = mlfq_pkg::S_BCHK;
            end
            mlfq_pkg::S_BCHK: begin
                if (r_boost >= r_interval) begin
                    n_boost = '0;
                    n_lvl   = LW'(1);
                    n_state = mlfq_pkg::S_BSCAN;
                end else begin
                    n_state = mlfq_pkg::S_DONE;
                end
            end
            mlfq_pkg::S_BSCAN: begin
                if (q_count == '0) begin
                    if (r_lvl == LAST_LVL) begin
                        n_state = mlfq_pkg::S_DONE;
                    end else begin
                        n_lvl = r_lvl + 1'b1;
                    end
                end else begin
                    n_state = mlfq_pkg::S_BMOVE;
                end
            end
            mlfq_pkg::S_BMOVE: begin
                // move the head of this level to the tail of the top level
                ram_we     = 1'b1;
                ram_waddr  = AW'(q_tail0);
                qcmd.pop   = 1'b1;
                qcmd.push0 = 1'b1;
                n_state    = mlfq_pkg::S_BSCAN;
            end
            mlfq_pkg::S_DONE: begin
                if (!r_ov || o_out.ready) begin
                    n_ov    = 1'b1;
                    n_out   = r_res;
                    n_state = mlfq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mlfq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mlfq_pkg::S_IDLE;
            r_lvl      <= '0;
            r_time     <= '0;
            r_boost    <= '0;
            r_ov       <= 1'b0;
            r_quantum  <= mlfq_pkg::QUANTUM_RESET;
            r_interval <= mlfq_pkg::BOOST_RESET;
        end else begin
            r_state <= n_state;
            r_lvl   <= n_lvl;
            r_time  <= n_time;
            r_boost <= n_boost;
            r_ov    <= n_ov;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    mlfq_pkg::CFG_QUANTUM: begin
                        r_quantum <= i_cfg_wdata[mlfq_pkg::QUANTUM_W-1:0];
                    end
                    mlfq_pkg::CFG_BOOST_INTERVAL: begin
                        r_interval <= i_cfg_wdata[mlfq_pkg::BOOST_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item  <= n_item;
        r_res   <= n_res;
        r_wtask <= n_wtask;
        r_out   <= n_out;
    end

endmodule

`default_nettype wire
